[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the filter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, masked during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// Implication into the next cycle, masked during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

// Implication into the next cycle, checked in reset too.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

[rtl/core/biq_pkg.sv]
// ---------------------------------------------------------------------------
// biq_pkg
// Types, widths and the control store of the multichannel biquad filter.
// ---------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

  // Defaults for the top level parameters
  localparam int MAX_CHANNELS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;

  // Fixed widths
  localparam int COEF_W    = 32;
  localparam int DELAY_W   = 40;
  localparam int HALF_W    = 20;            // low part of a delay word per multiply
  localparam int MUL_W     = HALF_W + 1;    // signed delay operand of the multiplier
  localparam int PROD_W    = COEF_W + MUL_W;
  localparam int ACC_W     = 74;            // three full products plus rounding
  localparam int CFG_IDX_W = 3;
  localparam int CH_IN_W   = 3;
  localparam int COUNT_W   = 4;
  localparam int STEP_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CO_B0, CO_B1, CO_B2, CO_A1, CO_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    D_W1, D_W2, D_W
  } dsel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD_X, ACC_ADD, ACC_CLEAR
  } acc_op_t;

  typedef enum logic [1:0] {
    RND_NONE, RND_W, RND_Y
  } rnd_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_PASS, JMP_EMIT
  } jmp_t;

  // One control word per step
  typedef struct packed {
    coef_sel_t coef;
    dsel_t     dsel;
    logic      hi;    // multiply the upper part of the delay word
    logic      neg;   // subtract this product
    acc_op_t   acc;   // acts on the product of the previous step
    rnd_op_t   rnd;
    jmp_t      jmp;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd14;

  // Control store. Steps 0-5 form w, steps 6-13 form y, step 14 hands off.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{CO_B0, D_W, 1'b0, 1'b0, ACC_NONE, RND_NONE, JMP_NEXT};
    case (step)
      4'd0:  w = '{CO_A1, D_W1, 1'b0, 1'b1, ACC_LOAD_X, RND_NONE, JMP_PASS};
      4'd1:  w = '{CO_A1, D_W1, 1'b1, 1'b1, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd2:  w = '{CO_A2, D_W2, 1'b0, 1'b1, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd3:  w = '{CO_A2, D_W2, 1'b1, 1'b1, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd4:  w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd5:  w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_CLEAR,  RND_W,    JMP_NEXT};
      4'd6:  w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_NONE,   RND_NONE, JMP_NEXT};
      4'd7:  w = '{CO_B0, D_W,  1'b1, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd8:  w = '{CO_B1, D_W1, 1'b0, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd9:  w = '{CO_B1, D_W1, 1'b1, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd10: w = '{CO_B2, D_W2, 1'b0, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd11: w = '{CO_B2, D_W2, 1'b1, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd12: w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_ADD,    RND_NONE, JMP_NEXT};
      4'd13: w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_NONE,   RND_Y,    JMP_NEXT};
      4'd14: w = '{CO_B0, D_W,  1'b0, 1'b0, ACC_NONE,   RND_NONE, JMP_EMIT};
      default: w = '{CO_B0, D_W, 1'b0, 1'b0, ACC_NONE, RND_NONE, JMP_EMIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/biquad_iir_multichannel.sv]
// ---------------------------------------------------------------------------
// biquad_iir_multichannel
// Multichannel second-order IIR filter, direct form II, run by a microcoded
// sequencer around one shared 32x21 multiplier and a 74-bit accumulator.
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   input   | in_valid / in_ready  | sample_in, channel_in
//   output  | out_valid / out_ready| sample_out, channel_out
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// A filtered item runs the whole control store from accept to the output
// register; the delay store is read at the accepting edge. Each of the
// five taps needs two passes through the multiplier since a delay word is
// 40 bits wide. A pass-through item (channel not in use) skips to hand-off.
// One item is in work at a time; in_ready is low while it runs. The output
// register frees the input side: the next item may start while a result
// waits, and only the hand-off step stalls on a full output register.
// Reset and any write of the channel count clear the delay store at once
// through per-channel valid bits; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module biquad_iir_multichannel #(
  parameter int MAX_CHANNELS   = biq_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic [biq_pkg::CH_IN_W-1:0]         channel_in,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic [biq_pkg::CH_IN_W-1:0]         channel_out,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]          cfg_data
);
  import biq_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] W_MAX = (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] W_MIN = ~W_MAX;
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  // configuration registers
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [COUNT_W-1:0]       channels_in_use;
  logic                     cfg_we;
  logic                     count_we;

  // sequencer
  logic                busy, busy_next;
  logic [STEP_W-1:0]   pc, pc_next;
  ucode_t              uc;
  logic                accept;
  logic                emit;
  logic                out_load;

  // item registers
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic [CH_IN_W-1:0]            ch_reg;
  logic                          pass_reg;
  logic [CH_W-1:0]               addr_reg;
  logic [CH_W-1:0]               in_addr;
  logic                          in_pass;

  // delay store: {w2, w1} per channel, valid bit per channel
  logic [2*DELAY_W-1:0] dstore [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] dvalid;
  logic [2*DELAY_W-1:0] rd_word;
  logic                 rd_ok;
  logic                 store_we;
  logic signed [DELAY_W-1:0] w1, w2, w_reg;

  // datapath
  logic signed [COEF_W-1:0]  mul_coef;
  logic signed [DELAY_W-1:0] mul_d;
  logic signed [MUL_W-1:0]   mul_op;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_hi, prod_neg;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   rnd_sum, rnd_q;
  logic signed [DELAY_W-1:0] w_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat, y_reg;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign count_we  = cfg_we && (cfg_index == REG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0         <= COEF_W'(64'd1 << COEF_FRAC_BITS);
      coef_b1         <= '0;
      coef_b2         <= '0;
      coef_a1         <= '0;
      coef_a2         <= '0;
      channels_in_use <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:    coef_b0 <= cfg_data;
        REG_B1:    coef_b1 <= cfg_data;
        REG_B2:    coef_b2 <= cfg_data;
        REG_A1:    coef_a1 <= cfg_data;
        REG_A2:    coef_a2 <= cfg_data;
        REG_COUNT: channels_in_use <= cfg_data[COUNT_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign uc       = ucode_rom(pc);
  assign emit     = busy && (uc.jmp == JMP_EMIT);
  assign out_load = emit && (!out_valid || out_ready);

  // channels past the count or past the store pass straight through
  assign in_pass = ({1'b0, channel_in} >= channels_in_use) ||
                   (32'(channel_in) >= 32'(MAX_CHANNELS));
  assign in_addr = CH_W'(channel_in);

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (accept) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (busy) begin
      if (uc.jmp == JMP_EMIT) begin
        if (out_load) begin
          busy_next = 1'b0;
        end
      end else if (uc.jmp == JMP_PASS && pass_reg) begin
        pc_next = STEP_EMIT;
      end else begin
        pc_next = pc + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg    <= sample_in;
      ch_reg   <= channel_in;
      pass_reg <= in_pass;
      addr_reg <= in_addr;
    end
  end

  // ---------------- delay store ----------------
  assign store_we = busy && (uc.rnd == RND_Y);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= dstore[in_addr];
    end
    if (store_we) begin
      dstore[addr_reg] <= {w1, w_reg};   // w2 <- w1, w1 <- w
    end
  end

  always_ff @(posedge clk) begin
    if (rst || count_we) begin
      dvalid <= '0;
    end else if (store_we) begin
      dvalid[addr_reg] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok <= dvalid[in_addr];
    end
  end

  // entries not yet written since the last clear read as zero
  assign w1 = rd_ok ? rd_word[DELAY_W-1:0]         : '0;
  assign w2 = rd_ok ? rd_word[2*DELAY_W-1:DELAY_W] : '0;

  // ---------------- multiplier ----------------
  always_comb begin
    case (uc.coef)
      CO_B0:   mul_coef = coef_b0;
      CO_B1:   mul_coef = coef_b1;
      CO_B2:   mul_coef = coef_b2;
      CO_A1:   mul_coef = coef_a1;
      CO_A2:   mul_coef = coef_a2;
      default: mul_coef = coef_b0;
    endcase
    case (uc.dsel)
      D_W1:    mul_d = w1;
      D_W2:    mul_d = w2;
      D_W:     mul_d = w_reg;
      default: mul_d = w_reg;
    endcase
    // upper part signed, lower part as a nonnegative number
    mul_op = uc.hi ? {mul_d[DELAY_W-1], mul_d[DELAY_W-1:HALF_W]}
                   : {1'b0, mul_d[HALF_W-1:0]};
  end

  always_ff @(posedge clk) begin
    prod     <= PROD_W'(mul_coef) * PROD_W'(mul_op);
    prod_hi  <= uc.hi;
    prod_neg <= uc.neg;
  end

  // ---------------- accumulator ----------------
  assign term = prod_hi ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (busy) begin
      case (uc.acc)
        ACC_LOAD_X: acc <= ACC_W'(x_reg) <<< COEF_FRAC_BITS;
        ACC_ADD:    acc <= prod_neg ? acc - term : acc + term;
        ACC_CLEAR:  acc <= '0;
        default:    acc <= acc;
      endcase
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd_sum = acc + ROUND_HALF;
    rnd_q   = rnd_sum >>> COEF_FRAC_BITS;
    if (rnd_q > W_MAX) begin
      w_sat = W_MAX[DELAY_W-1:0];
    end else if (rnd_q < W_MIN) begin
      w_sat = W_MIN[DELAY_W-1:0];
    end else begin
      w_sat = rnd_q[DELAY_W-1:0];
    end
    if (rnd_q > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (rnd_q < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (busy && uc.rnd == RND_W) begin
      w_reg <= w_sat;
    end
    if (busy && uc.rnd == RND_Y) begin
      y_reg <= y_sat;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out  <= pass_reg ? x_reg : y_reg;
      channel_out <= ch_reg;
    end
  end

endmodule

`default_nettype wire

[rtl/core/biq_checker.sv]
// ---------------------------------------------------------------------------
// biq_checker
// Port-level checks on the biquad filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module biq_checker #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [SAMPLE_BITS-1:0]        sample_out,
  input logic [biq_pkg::CH_IN_W-1:0]   channel_out,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // one item in work at a time
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // result held while stalled
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
               $stable(sample_out) && $stable(channel_out))

  // register writes are never back-pressured
  `ASSERT_IMPLY(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

  // reset leaves the block empty and ready
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && in_ready)

endmodule

bind biquad_iir_multichannel biq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_biq_checker (.*);

`default_nettype wire
